// ===== rtl/core/id_allocator_free_queue_defines.svh =====
// Assertion helpers for the identifier allocator.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ID_ALLOCATOR_FREE_QUEUE_DEFINES_SVH
`define ID_ALLOCATOR_FREE_QUEUE_DEFINES_SVH
`ifndef SYNTH
`define IDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define IDA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define IDA_ASSERT(lbl, prop, msg)
`define IDA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/core/idalloc_pkg.sv =====
`default_nettype none

package idalloc_pkg;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_GET_LOW = 2'd1,
		CMD_RETURN  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Register word index, taken from paddr[2].
	localparam logic REG_BASE_ID = 1'b0;

	localparam int CFG_DATA_W = 32;
	localparam int BASE_FIELD_W = 16;

endpackage

`default_nettype wire

// ===== rtl/core/id_allocator_free_queue.sv =====
// Throughput: one request per cycle while rsp_ready is high or no response is pending;
// the only loop is the counter and free queue update. Responses are registered.
// The free queue head is prefetched from its memory into a register every cycle.
// Reset (arst_n low, asynchronous): counter and base at zero, not exhausted, queue empty,
// no response pending. Queue memory contents are undefined until written.
`default_nettype none
`include "id_allocator_free_queue_defines.svh"

module id_allocator_free_queue
	import idalloc_pkg::*;
#(
	parameter int ID_WIDTH = 16,
	parameter int FREE_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [2:0]            paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [1:0]            command,
	input  wire logic [ID_WIDTH-1:0]   id_value,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic      [ID_WIDTH-1:0]   id_out,
	output logic      [1:0]            status,
	output logic      [ID_WIDTH:0]     reserved_count
);

	localparam int PTR_W = $clog2(FREE_DEPTH);
	localparam int CNT_W = $clog2(FREE_DEPTH + 1);
	localparam int DIFF_W = ((ID_WIDTH > CNT_W) ? ID_WIDTH : CNT_W) + 3;
	localparam int CFG_W = (ID_WIDTH < BASE_FIELD_W) ? ID_WIDTH : BASE_FIELD_W;
	localparam logic [ID_WIDTH-1:0] ID_TOP = {ID_WIDTH{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(FREE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FREE_DEPTH - 1);
	localparam logic signed [DIFF_W-1:0] RSV_MAX = DIFF_W'(1) << ID_WIDTH;

	logic [ID_WIDTH-1:0] base_q;
	logic [ID_WIDTH-1:0] next_q;
	logic                exh_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_WIDTH-1:0] head_data_q;
	logic [ID_WIDTH-1:0] mem [FREE_DEPTH];

	logic [ID_WIDTH-1:0] id_out_q;
	logic [1:0]          status_q;
	logic [ID_WIDTH:0]   rsv_q;
	logic                rsp_valid_q;

	logic                req_fire;
	logic                cfg_write;
	logic                pop;
	logic                push;
	logic [ID_WIDTH-1:0] next_n;
	logic                exh_n;
	logic [PTR_W-1:0]    head_n;
	logic [PTR_W-1:0]    tail_n;
	logic [CNT_W-1:0]    count_n;
	logic [ID_WIDTH-1:0] id_n;
	status_t             status_n;
	logic signed [DIFF_W-1:0] rsv_diff;
	logic [ID_WIDTH:0]   rsv_n;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BASE_ID);
	assign prdata = (paddr[2] == REG_BASE_ID) ? CFG_DATA_W'(base_q) : '0;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire = req_valid && req_ready;

	assign rsp_valid = rsp_valid_q;
	assign id_out = id_out_q;
	assign status = status_q;
	assign reserved_count = rsv_q;

	always_comb begin
		logic take_counter;
		pop = 1'b0;
		push = 1'b0;
		take_counter = 1'b0;
		next_n = next_q;
		exh_n = exh_q;
		id_n = '0;
		status_n = ST_OK;
		case (command) inside
			CMD_GET, CMD_GET_LOW: begin
				// A low get drains the queue first; a plain get does so only when exhausted.
				if (count_q != '0 && (exh_q || command == CMD_GET_LOW)) begin
					pop = 1'b1;
					id_n = head_data_q;
				end else if (exh_q) begin
					status_n = ST_EMPTY;
				end else begin
					take_counter = 1'b1;
				end
			end
			CMD_RETURN: begin
				if (exh_q && id_value == next_q) begin
					exh_n = 1'b0;
				end else if (!exh_q && id_value == next_q - 1'b1) begin
					next_n = next_q - 1'b1;
				end else if (count_q == COUNT_FULL) begin
					status_n = ST_FULL;
				end else begin
					push = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (take_counter) begin
			id_n = next_q;
			if (next_q == ID_TOP) begin
				exh_n = 1'b1;
			end else begin
				next_n = next_q + 1'b1;
			end
		end
	end

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		count_n = count_q;
		if (req_fire && pop) begin
			head_n = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			count_n = count_q - 1'b1;
		end
		if (req_fire && push) begin
			tail_n = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			count_n = count_q + 1'b1;
		end
	end

	// Reserved count after the step, saturated to 0 .. 2^ID_WIDTH.
	always_comb begin
		rsv_diff = $signed(DIFF_W'(next_n)) - $signed(DIFF_W'(base_q))
			- $signed(DIFF_W'(count_n)) + $signed(DIFF_W'(exh_n));
		if (rsv_diff[DIFF_W-1]) begin
			rsv_n = '0;
		end else if (rsv_diff > RSV_MAX) begin
			rsv_n = RSV_MAX[ID_WIDTH:0];
		end else begin
			rsv_n = rsv_diff[ID_WIDTH:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
			exh_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				base_q <= ID_WIDTH'(pwdata[CFG_W-1:0]);
				next_q <= ID_WIDTH'(pwdata[CFG_W-1:0]);
				exh_q <= 1'b0;
			end else if (req_fire) begin
				next_q <= next_n;
				exh_q <= exh_n;
			end
			head_q <= head_n;
			tail_q <= tail_n;
			count_q <= count_n;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_out_q <= id_n;
			status_q <= status_n;
			rsv_q <= rsv_n;
		end
	end

	// The head entry is read ahead so a pop never waits on the memory.
	// A push into an empty queue lands on the head slot and is forwarded.
	always_ff @(posedge clk) begin
		if (req_fire && push) begin
			mem[tail_q] <= id_value;
		end
		if (req_fire && push && tail_q == head_n) begin
			head_data_q <= id_value;
		end else begin
			head_data_q <= mem[head_n];
		end
	end

	`IDA_ASSERT(a_count_bound, count_q <= COUNT_FULL, "free queue count above depth")
	`IDA_ASSERT(a_empty_ptrs, (count_q != '0) || (head_q == tail_q), "empty queue with split pointers")
	`IDA_ASSERT(a_exh_top, !exh_q || (next_q == ID_TOP), "exhausted mode below top value")
	`IDA_ASSERT_NEXT(a_pop_count, req_fire && pop, count_q == $past(count_q) - 1'b1, "pop did not lower count")
	`IDA_ASSERT_NEXT(a_full_drop, req_fire && status_n == ST_FULL, count_q == COUNT_FULL, "drop without full queue")

endmodule

`default_nettype wire
